// ===== src/rpi_pkg.sv =====
package rpi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int IN_W   = 32;
    localparam int NRM_W  = 18;
    localparam int EPS_W  = 17;
    localparam int PROD_W = IN_W + NRM_W;
    localparam int DEN_W  = PROD_W + 2;

    // quotient bits kept by the divider; t saturates at 2^33
    localparam int Q_W = 34;
    localparam logic [Q_W-1:0] TCAP = {2'b10, {(Q_W-2){1'b0}}};

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 3'd4;

    localparam logic [NRM_W-1:0] NORMAL_X_RST = 18'd0;
    localparam logic [NRM_W-1:0] NORMAL_Y_RST = 18'd0;
    localparam logic [NRM_W-1:0] NORMAL_Z_RST = 18'd65536;
    localparam logic [IN_W-1:0]  OFFSET_RST   = 32'd0;
    localparam logic [EPS_W-1:0] EPSILON_RST  = 17'd1;

    // ray data that rides along with the arithmetic
    typedef struct packed {
        logic [2:0][IN_W-1:0] orig;
        logic [2:0][IN_W-1:0] dirv;
        logic [IN_W-1:0]      tmin;
        logic [IN_W-1:0]      tmax;
        logic                 neg;
        logic                 den_pos;
        logic                 live;
    } t_side;

endpackage

// ===== src/ray_plane_intersect.sv =====
// Ray/plane intersection in Q16.16 (fraction width set by FRAC_BITS). The plane
// n.x + d = 0 and the parallel threshold come from five configuration registers
// (normal x/y/z, offset, epsilon) that may be written only while no ray is in
// flight. Each ray gives exactly one result: on a hit, t, the hit point and the
// normal turned to face the ray; otherwise every field is zero. The block takes
// one ray per cycle unless the output stalls; most of its pipeline is the
// 34-stage radix-2 divider that forms t, one quotient bit per stage. A stall at
// the output freezes the whole pipeline, but an empty first stage still accepts.
module ray_plane_intersect
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [IN_W-1:0]         i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [IN_W-1:0]  i_origin_x,
    input  logic signed [IN_W-1:0]  i_origin_y,
    input  logic signed [IN_W-1:0]  i_origin_z,
    input  logic signed [IN_W-1:0]  i_direction_x,
    input  logic signed [IN_W-1:0]  i_direction_y,
    input  logic signed [IN_W-1:0]  i_direction_z,
    input  logic signed [IN_W-1:0]  i_t_min,
    input  logic signed [IN_W-1:0]  i_t_max,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic signed [IN_W-1:0]  o_t_hit,
    output logic signed [IN_W-1:0]  o_point_x,
    output logic signed [IN_W-1:0]  o_point_y,
    output logic signed [IN_W-1:0]  o_point_z,
    output logic signed [NRM_W-1:0] o_facing_x,
    output logic signed [NRM_W-1:0] o_facing_y,
    output logic signed [NRM_W-1:0] o_facing_z
);

    localparam int OFS_W = IN_W + FRAC_BITS;
    localparam int NUM_W = ((OFS_W > DEN_W) ? OFS_W : DEN_W) + 2;
    localparam int T_W   = Q_W + 1;
    localparam int MUL_W = 2 * IN_W;
    localparam int PT_W  = MUL_W + 1;

    function automatic logic signed [IN_W-1:0] sat32(input logic signed [PT_W-1:0] v);
        logic signed [PT_W-1:0] hi;
        logic signed [PT_W-1:0] lo;
        hi = PT_W'({1'b0, {(IN_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[IN_W-1:0];
        end else if (v < lo) begin
            return lo[IN_W-1:0];
        end
        return v[IN_W-1:0];
    endfunction

    function automatic logic signed [NRM_W-1:0] neg_sat(input logic signed [NRM_W-1:0] n);
        if (n == {1'b1, {(NRM_W-1){1'b0}}}) begin
            return {1'b0, {(NRM_W-1){1'b1}}};
        end
        return -n;
    endfunction

    // configuration
    logic signed [NRM_W-1:0] r_normal [3];
    logic signed [IN_W-1:0]  r_offset;
    logic [EPS_W-1:0]        r_eps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal[0] <= NORMAL_X_RST;
            r_normal[1] <= NORMAL_Y_RST;
            r_normal[2] <= NORMAL_Z_RST;
            r_offset    <= OFFSET_RST;
            r_eps       <= EPSILON_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NORMAL_X: r_normal[0] <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Y: r_normal[1] <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Z: r_normal[2] <= i_cfg_data[NRM_W-1:0];
                CFG_OFFSET:   r_offset    <= i_cfg_data;
                CFG_EPSILON:  r_eps       <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [IN_W-1:0] w_orig [3];
    logic signed [IN_W-1:0] w_dir  [3];

    assign w_orig[0] = i_origin_x;
    assign w_orig[1] = i_origin_y;
    assign w_orig[2] = i_origin_z;
    assign w_dir[0]  = i_direction_x;
    assign w_dir[1]  = i_direction_y;
    assign w_dir[2]  = i_direction_z;

    // the whole pipeline advances unless a result waits at the output
    logic w_en;
    logic r_out_valid;
    logic r_s1_valid;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en || !r_s1_valid;

    // stage 1: products
    t_side                    r_s1_side;
    logic signed [PROD_W-1:0] r_s1_pd [3];
    logic signed [PROD_W-1:0] r_s1_pn [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_side.orig[i] <= w_orig[i];
                r_s1_side.dirv[i] <= w_dir[i];
                r_s1_pd[i]        <= w_dir[i] * r_normal[i];
                r_s1_pn[i]        <= w_orig[i] * r_normal[i];
            end
            r_s1_side.tmin    <= i_t_min;
            r_s1_side.tmax    <= i_t_max;
            r_s1_side.neg     <= 1'b0;
            r_s1_side.den_pos <= 1'b0;
            r_s1_side.live    <= 1'b0;
        end
    end

    // stage 2: dot products, numerator negated with the offset folded in
    logic                    r_s2_valid;
    t_side                   r_s2_side;
    logic signed [DEN_W-1:0] r_s2_den;
    logic signed [NUM_W-1:0] r_s2_num;
    logic signed [NUM_W-1:0] w_ofs;

    assign w_ofs = NUM_W'(r_offset) <<< FRAC_BITS;

    // stage 3: magnitudes, sign and parallel test
    logic                    r_s3_valid;
    t_side                   r_s3_side;
    logic [NUM_W-1:0]        r_s3_an;
    logic [DEN_W-1:0]        r_s3_ad;
    logic signed [DEN_W-1:0] w_eps;

    assign w_eps = $signed(DEN_W'({r_eps, {FRAC_BITS{1'b0}}}));

    // divider output
    logic           w_dv_valid;
    t_side          w_dv_side;
    logic [Q_W-1:0] w_dv_quot;

    // stage 4: signed t
    logic                  r_s4_valid;
    t_side                 r_s4_side;
    logic signed [T_W-1:0] r_s4_t;

    // stage 5: interval test
    logic                   r_s5_valid;
    t_side                  r_s5_side;
    logic                   r_s5_hit;
    logic signed [IN_W-1:0] r_s5_t;

    // stage 6: t * direction
    logic                    r_s6_valid;
    t_side                   r_s6_side;
    logic                    r_s6_hit;
    logic signed [IN_W-1:0]  r_s6_t;
    logic signed [MUL_W-1:0] r_s6_prod [3];

    // stage 7: output register
    logic                    r_hit;
    logic signed [IN_W-1:0]  r_t_hit;
    logic signed [IN_W-1:0]  r_point  [3];
    logic signed [NRM_W-1:0] r_facing [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= w_dv_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_out_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side <= r_s1_side;
            r_s2_den  <= DEN_W'(r_s1_pd[0]) + DEN_W'(r_s1_pd[1]) + DEN_W'(r_s1_pd[2]);
            r_s2_num  <= -(NUM_W'(r_s1_pn[0]) + NUM_W'(r_s1_pn[1])
                           + NUM_W'(r_s1_pn[2]) + w_ofs);

            r_s3_side.orig    <= r_s2_side.orig;
            r_s3_side.dirv    <= r_s2_side.dirv;
            r_s3_side.tmin    <= r_s2_side.tmin;
            r_s3_side.tmax    <= r_s2_side.tmax;
            r_s3_side.neg     <= r_s2_num[NUM_W-1] != r_s2_den[DEN_W-1];
            r_s3_side.den_pos <= r_s2_den > 0;
            r_s3_side.live    <= (r_s2_den > w_eps) || (r_s2_den < -w_eps);
            r_s3_an           <= r_s2_num[NUM_W-1] ? NUM_W'(-r_s2_num) : r_s2_num;
            r_s3_ad           <= r_s2_den[DEN_W-1] ? DEN_W'(-r_s2_den) : r_s2_den;

            r_s4_side <= w_dv_side;
            r_s4_t    <= w_dv_side.neg ? -$signed(T_W'(w_dv_quot))
                                       : $signed(T_W'(w_dv_quot));

            r_s5_side <= r_s4_side;
            r_s5_hit  <= r_s4_side.live
                         && (r_s4_t >= T_W'($signed(r_s4_side.tmin)))
                         && (r_s4_t <= T_W'($signed(r_s4_side.tmax)));
            r_s5_t    <= r_s4_t[IN_W-1:0];

            r_s6_side <= r_s5_side;
            r_s6_hit  <= r_s5_hit;
            r_s6_t    <= r_s5_t;
            for (int i = 0; i < 3; i++) begin
                r_s6_prod[i] <= r_s5_t * $signed(r_s5_side.dirv[i]);
            end

            // drop every field on a miss
            r_hit   <= r_s6_hit;
            r_t_hit <= r_s6_hit ? r_s6_t : '0;
            for (int i = 0; i < 3; i++) begin
                r_point[i]  <= r_s6_hit
                               ? sat32(PT_W'($signed(r_s6_side.orig[i]))
                                       + PT_W'(r_s6_prod[i] >>> FRAC_BITS))
                               : '0;
                r_facing[i] <= !r_s6_hit ? '0
                             : (r_s6_side.den_pos ? neg_sat(r_normal[i]) : r_normal[i]);
            end
        end
    end

    rpi_div #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_valid),
        .i_side  (r_s3_side),
        .i_num   (r_s3_an),
        .i_den   (r_s3_ad),
        .o_valid (w_dv_valid),
        .o_side  (w_dv_side),
        .o_quot  (w_dv_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_t_hit     = r_t_hit;
    assign o_point_x   = r_point[0];
    assign o_point_y   = r_point[1];
    assign o_point_z   = r_point[2];
    assign o_facing_x  = r_facing[0];
    assign o_facing_y  = r_facing[1];
    assign o_facing_z  = r_facing[2];

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_t_hit == 0 && o_point_x == 0 && o_point_y == 0
            && o_point_z == 0 && o_facing_x == 0 && o_facing_y == 0 && o_facing_z == 0)
        else $error("miss result carries nonzero fields");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== src/rpi_div.sv =====
module rpi_div
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NUM_W     = DEN_W + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output t_side            o_side,
    output logic [Q_W-1:0]   o_quot
);

    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int HI_W  = DVD_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DVD_W-1:0] w_dvd;
    logic [CMP_W-1:0] w_hi;
    logic [CMP_W-1:0] w_den_x;
    logic             w_ovf;

    logic [Q_W:0]       r_v;
    t_side              r_side [Q_W+1];
    logic [DEN_W-1:0]   r_rem  [Q_W+1];
    logic [DEN_W-1:0]   r_den  [Q_W+1];
    logic [Q_W-1:0]     r_lo   [Q_W+1];
    logic [Q_W-1:0]     r_q    [Q_W+1];
    logic               r_ovf  [Q_W+1];

    logic [DEN_W:0]     w_trial [Q_W];
    logic               w_ge    [Q_W];
    logic [DEN_W-1:0]   n_rem   [Q_W];

    assign w_dvd   = {i_num, {FRAC_BITS{1'b0}}};
    assign w_hi    = CMP_W'(w_dvd[DVD_W-1:Q_W]);
    assign w_den_x = CMP_W'(i_den);
    // quotient would not fit in Q_W bits: saturate
    assign w_ovf   = w_hi >= w_den_x;

    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            w_trial[j] = {r_rem[j], r_lo[j][Q_W-1]};
            w_ge[j]    = w_trial[j] >= {1'b0, r_den[j]};
            n_rem[j]   = w_ge[j] ? DEN_W'(w_trial[j] - {1'b0, r_den[j]})
                                 : w_trial[j][DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Q_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_rem[0]  <= w_ovf ? '0 : DEN_W'(w_hi);
            r_den[0]  <= i_den;
            r_lo[0]   <= w_dvd[Q_W-1:0];
            r_q[0]    <= '0;
            r_ovf[0]  <= w_ovf;
            for (int j = 0; j < Q_W; j++) begin
                r_side[j+1] <= r_side[j];
                r_rem[j+1]  <= n_rem[j];
                r_den[j+1]  <= r_den[j];
                r_lo[j+1]   <= {r_lo[j][Q_W-2:0], 1'b0};
                r_q[j+1]    <= {r_q[j][Q_W-2:0], w_ge[j]};
                r_ovf[j+1]  <= r_ovf[j];
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_side  = r_side[Q_W];
    assign o_quot  = (r_ovf[Q_W] || (r_q[Q_W][Q_W-1] && (|r_q[Q_W][Q_W-2:0])))
                     ? TCAP : r_q[Q_W];

`ifndef SYNTHESIS
    a_quot_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quot <= TCAP)
        else $error("divider quotient above saturation cap");
`endif

endmodule

// ===== bench/tb.sv =====
module tb
    import rpi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;
    localparam int ONE = 1 << FB;
    localparam logic signed [IN_W-1:0] QMAX = 32'sh7fff_ffff;
    localparam logic signed [IN_W-1:0] QMIN = 32'sh8000_0000;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [IN_W-1:0] ox;
        logic signed [IN_W-1:0] oy;
        logic signed [IN_W-1:0] oz;
        logic signed [IN_W-1:0] dx;
        logic signed [IN_W-1:0] dy;
        logic signed [IN_W-1:0] dz;
        logic signed [IN_W-1:0] tmin;
        logic signed [IN_W-1:0] tmax;
    } ray_t;

    typedef struct packed {
        logic                    hit;
        logic signed [IN_W-1:0]  t_hit;
        logic signed [IN_W-1:0]  px;
        logic signed [IN_W-1:0]  py;
        logic signed [IN_W-1:0]  pz;
        logic signed [NRM_W-1:0] fx;
        logic signed [NRM_W-1:0] fy;
        logic signed [NRM_W-1:0] fz;
    } hit_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [IN_W-1:0]         i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic signed [IN_W-1:0]  i_origin_x = '0;
    logic signed [IN_W-1:0]  i_origin_y = '0;
    logic signed [IN_W-1:0]  i_origin_z = '0;
    logic signed [IN_W-1:0]  i_direction_x = '0;
    logic signed [IN_W-1:0]  i_direction_y = '0;
    logic signed [IN_W-1:0]  i_direction_z = '0;
    logic signed [IN_W-1:0]  i_t_min = '0;
    logic signed [IN_W-1:0]  i_t_max = '0;
    logic                    i_out_ready = 1'b0;

    logic                    o_cfg_ready;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic                    o_hit;
    logic signed [IN_W-1:0]  o_t_hit;
    logic signed [IN_W-1:0]  o_point_x;
    logic signed [IN_W-1:0]  o_point_y;
    logic signed [IN_W-1:0]  o_point_z;
    logic signed [NRM_W-1:0] o_facing_x;
    logic signed [NRM_W-1:0] o_facing_y;
    logic signed [NRM_W-1:0] o_facing_z;

    // plane as the block should currently hold it
    logic signed [NRM_W-1:0] pl_nx = NORMAL_X_RST;
    logic signed [NRM_W-1:0] pl_ny = NORMAL_Y_RST;
    logic signed [NRM_W-1:0] pl_nz = NORMAL_Z_RST;
    logic signed [IN_W-1:0]  pl_d = OFFSET_RST;
    logic [EPS_W-1:0]        pl_eps = EPSILON_RST;

    hit_t pending_hits[$];
    int   n_fail = 0;
    int   n_cycles = 0;
    bit   tx_idle_on = 1'b0;
    bit   rx_stall_on = 1'b0;
    int   rx_hold_req = 0;
    int   rx_hold_cnt = 0;
    int   rx_gap_cnt = 0;

    ray_plane_intersect u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_origin_z    (i_origin_z),
        .i_direction_x (i_direction_x),
        .i_direction_y (i_direction_y),
        .i_direction_z (i_direction_z),
        .i_t_min       (i_t_min),
        .i_t_max       (i_t_max),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_t_hit       (o_t_hit),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_facing_x    (o_facing_x),
        .o_facing_y    (o_facing_y),
        .o_facing_z    (o_facing_z)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [IN_W-1:0] sat32(longint v);
        if (v > longint'(QMAX)) return QMAX;
        if (v < longint'(QMIN)) return QMIN;
        return v[IN_W-1:0];
    endfunction

    function automatic logic [NRM_W-1:0] sat18(longint v);
        if (v > 131071) return 18'sh1ffff;
        if (v < -131072) return 18'sh20000;
        return v[NRM_W-1:0];
    endfunction

    function automatic hit_t predict_hit(ray_t r);
        longint org[3], dv[3], nv[3], pt[3], fc[3];
        longint den, num, t;
        logic [127:0] mag_n, mag_d, quo;
        hit_t res;
        res = '0;
        org[0] = $signed(r.ox);
        org[1] = $signed(r.oy);
        org[2] = $signed(r.oz);
        dv[0] = $signed(r.dx);
        dv[1] = $signed(r.dy);
        dv[2] = $signed(r.dz);
        nv[0] = pl_nx;
        nv[1] = pl_ny;
        nv[2] = pl_nz;
        den = 0;
        num = 0;
        for (int i = 0; i < 3; i++) begin
            den += dv[i] * nv[i];
            num += nv[i] * org[i];
        end
        num = -(num + longint'(pl_d) * ONE);
        if ((den < 0 ? -den : den) > (longint'(pl_eps) <<< FB)) begin
            mag_n = (num < 0) ? -num : num;
            mag_d = (den < 0) ? -den : den;
            quo = (mag_n << FB) / mag_d;
            if (quo > TCAP) quo = TCAP;
            t = longint'(quo[63:0]);
            if ((num < 0) != (den < 0)) t = -t;
            if (t >= longint'($signed(r.tmin)) && t <= longint'($signed(r.tmax))) begin
                for (int i = 0; i < 3; i++) begin
                    pt[i] = org[i] + ((t * dv[i]) >>> FB);
                    fc[i] = (den > 0) ? -nv[i] : nv[i];
                end
                res.hit = 1'b1;
                res.t_hit = sat32(t);
                res.px = sat32(pt[0]);
                res.py = sat32(pt[1]);
                res.pz = sat32(pt[2]);
                res.fx = sat18(fc[0]);
                res.fy = sat18(fc[1]);
                res.fz = sat18(fc[2]);
            end
        end
        return res;
    endfunction

    // parameter where the ray meets the plane, ignoring the interval
    function automatic bit solve_t(ray_t r, output logic signed [IN_W-1:0] t);
        hit_t h;
        r.tmin = QMIN;
        r.tmax = QMAX;
        h = predict_hit(r);
        t = h.t_hit;
        return h.hit;
    endfunction

    function automatic ray_t mk_ray(longint ox, oy, oz, dx, dy, dz, tmin, tmax);
        ray_t r;
        r.ox = ox[31:0];
        r.oy = oy[31:0];
        r.oz = oz[31:0];
        r.dx = dx[31:0];
        r.dy = dy[31:0];
        r.dz = dz[31:0];
        r.tmin = tmin[31:0];
        r.tmax = tmax[31:0];
        return r;
    endfunction

    function automatic logic [IN_W-1:0] rand_q();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(6))
                    0: return QMAX;
                    1: return QMIN;
                    2: return '0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    5: return ONE;
                    default: return -ONE;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 1 << 23) - (1 << 22);
            default: return $urandom;
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        logic signed [IN_W-1:0] t;
        int k;
        r.ox = rand_q();
        r.oy = rand_q();
        r.oz = rand_q();
        r.dx = rand_q();
        r.dy = rand_q();
        r.dz = rand_q();
        r.tmin = rand_q();
        r.tmax = rand_q();
        k = $urandom_range(9);
        if (k < 4) begin
            r.tmin = QMIN;
            r.tmax = QMAX;
        end else if (k < 6) begin
            r.tmin = '0;
            r.tmax = QMAX;
        end else if (k < 9 && solve_t(r, t)) begin
            // land on or just past the interval bounds
            case (k)
                6: begin
                    r.tmin = t;
                    r.tmax = t + $urandom_range(0, 3);
                end
                7: begin
                    r.tmax = t;
                    r.tmin = t - $urandom_range(0, 3);
                end
                default: begin
                    if ($urandom_range(1)) r.tmin = t + 1;
                    else r.tmax = t - 1;
                end
            endcase
        end
        return r;
    endfunction

    function automatic longint rand_normal();
        case ($urandom_range(5))
            0: return 0;
            1: return ONE;
            2: return -ONE;
            3: return longint'($urandom_range(0, 2 * ONE)) - ONE;
            4: return longint'($signed($urandom_range(0, (1 << NRM_W) - 1) << 14)) >>> 14;
            default: return -131072;
        endcase
    endfunction

    // fill bits above the register width with junk the block must drop
    function automatic logic [IN_W-1:0] pad_word(longint v, int width);
        logic [IN_W-1:0] w;
        w = $urandom;
        for (int i = 0; i < width; i++) w[i] = v[i];
        return w;
    endfunction

    function automatic longint rand_eps();
        case ($urandom_range(3))
            0: return 0;
            1: return ONE;
            2: return $urandom_range(0, 300);
            default: return $urandom_range(0, (1 << EPS_W) - 1);
        endcase
    endfunction

    function automatic int pause_len();
        int k;
        k = $urandom_range(99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_ray(input ray_t r);
        int gap;
        gap = tx_idle_on ? pause_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_origin_x <= r.ox;
        i_origin_y <= r.oy;
        i_origin_z <= r.oz;
        i_direction_x <= r.dx;
        i_direction_y <= r.dy;
        i_direction_z <= r.dz;
        i_t_min <= r.tmin;
        i_t_max <= r.tmax;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_hits.push_back(predict_hit(r));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_hits.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NORMAL_X: pl_nx = data[NRM_W-1:0];
            CFG_NORMAL_Y: pl_ny = data[NRM_W-1:0];
            CFG_NORMAL_Z: pl_nz = data[NRM_W-1:0];
            CFG_OFFSET:   pl_d = data;
            CFG_EPSILON:  pl_eps = data[EPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_plane(input longint nx, ny, nz, d, eps);
        wait_drain();
        write_reg(CFG_NORMAL_X, pad_word(nx, NRM_W));
        write_reg(CFG_NORMAL_Y, pad_word(ny, NRM_W));
        write_reg(CFG_NORMAL_Z, pad_word(nz, NRM_W));
        write_reg(CFG_OFFSET, d[31:0]);
        write_reg(CFG_EPSILON, pad_word(eps, EPS_W));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_plane();
        ray_t b;
        logic signed [IN_W-1:0] t;
        // plane z = 0, threshold of one LSB
        send_ray(mk_ray(0, 0, 10 * ONE, 0, 0, -ONE, 0, QMAX));
        send_ray(mk_ray(ONE, 2 * ONE, -5 * ONE, 0, 0, ONE, 0, QMAX));
        send_ray(mk_ray(0, 0, ONE, ONE, 0, 0, QMIN, QMAX));
        send_ray(mk_ray(0, 0, -1, 0, 0, 1, QMIN, QMAX));
        send_ray(mk_ray(0, 0, -1, 0, 0, 2, QMIN, QMAX));
        send_ray(mk_ray(0, 0, -ONE, 0, 0, -ONE, 0, QMAX));
        send_ray(mk_ray(0, 0, -ONE, 0, 0, -ONE, QMIN, QMAX));
        send_ray(mk_ray(0, 0, ONE, 0, 0, -ONE, QMAX, QMIN));
        b = mk_ray(3 * ONE, -7 * ONE, 123456, 5000, -3, -70000, QMIN, QMAX);
        void'(solve_t(b, t));
        b.tmin = t;
        b.tmax = t;
        send_ray(b);
        b.tmin = t + 1;
        send_ray(b);
        b.tmin = t;
        b.tmax = t - 1;
        send_ray(b);
        send_ray(mk_ray(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
        send_ray(mk_ray(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0));
        // hit point runs off both ends of the range
        send_ray(mk_ray(QMAX, QMIN, -ONE, QMAX, QMIN, ONE, QMIN, QMAX));
        // t far beyond 32 bits, capped
        send_ray(mk_ray(0, 0, QMAX, 0, 0, -2, QMIN, QMAX));
        send_ray(mk_ray(-ONE, 3 * ONE, 2 * ONE, ONE / 2, -ONE, -ONE / 4, QMIN, QMAX));
    endtask

    task automatic test_odd_normals();
        // most negative normal component flips to the largest positive one
        load_plane(-131072, 0, 1, 0, 0);
        send_ray(mk_ray(4 * ONE, 0, 0, ONE, 0, 0, QMIN, QMAX));
        send_ray(mk_ray(4 * ONE, 0, 0, -ONE, 0, 0, QMIN, QMAX));
        send_ray(mk_ray(0, 0, -3, 0, 0, 1, QMIN, QMAX));
        // non-unit normal, threshold of 1.0
        load_plane(ONE, ONE, ONE, QMIN, ONE);
        send_ray(mk_ray(0, 0, 0, ONE, 0, 0, QMIN, QMAX));
        send_ray(mk_ray(0, 0, 0, ONE, 1, 0, QMIN, QMAX));
        send_ray(mk_ray(ONE, -ONE, 2 * ONE, -ONE, -ONE, -ONE, QMIN, QMAX));
        load_plane(rand_normal(), rand_normal(), rand_normal(), QMAX, (1 << EPS_W) - 1);
        repeat (4) send_ray(rand_ray());
    endtask

    task automatic test_ignored_index();
        wait_drain();
        for (int k = 1; k <= 3; k++) write_reg(CFG_IDX_W'(CFG_EPSILON + k), $urandom);
        i_cfg_valid <= 1'b0;
        repeat (20) send_ray(rand_ray());
    endtask

    task automatic test_random_planes();
        for (int ph = 0; ph < 8; ph++) begin
            load_plane(rand_normal(), rand_normal(), rand_normal(), rand_q(), rand_eps());
            tx_idle_on = (ph % 3 != 1);
            rx_stall_on = (ph % 3 != 2);
            repeat (55) send_ray(rand_ray());
        end
    endtask

    task automatic test_back_pressure();
        wait_drain();
        tx_idle_on = 1'b0;
        rx_stall_on = 1'b0;
        rx_hold_req = 300;
        repeat (100) send_ray(rand_ray());
        wait_drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_plane();
        test_odd_normals();
        test_ignored_index();
        test_random_planes();
        test_back_pressure();
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
        test_ignored_index();
        wait_drain();
        repeat (60) @(posedge i_clk);
        if (n_fail == 0 && pending_hits.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // receiver: long hold on request, otherwise random stalls while enabled
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_cnt = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            i_out_ready <= 1'b0;
        end else if (rx_gap_cnt > 0) begin
            rx_gap_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (rx_stall_on && $urandom_range(99) < 25) rx_gap_cnt = pause_len();
        end
    end

    always @(posedge i_clk) begin : check_out
        hit_t got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.hit = o_hit;
            got.t_hit = o_t_hit;
            got.px = o_point_x;
            got.py = o_point_y;
            got.pz = o_point_z;
            got.fx = o_facing_x;
            got.fy = o_facing_y;
            got.fz = o_facing_z;
            if (pending_hits.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("[%0t] result with no ray outstanding", $time);
            end else begin
                want = pending_hits.pop_front();
                if (got !== want) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("[%0t] mismatch exp: hit=%0d t=%0d p=(%0d,%0d,%0d) f=(%0d,%0d,%0d)",
                                 $time, want.hit, want.t_hit, want.px, want.py, want.pz,
                                 want.fx, want.fy, want.fz);
                        $display("            got: hit=%0d t=%0d p=(%0d,%0d,%0d) f=(%0d,%0d,%0d)",
                                 got.hit, got.t_hit, got.px, got.py, got.pz,
                                 got.fx, got.fy, got.fz);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
